/* design/llc_pkg.sv */
// Package for the LRU lookup cache: request/response words, cell command
// and the neighbor-chain struct passed between cells.
// No dependencies.
`default_nettype none

package llc_pkg;

	// Width of the capacity register
	localparam int CAP_BITS = 5;
	// Field widths of the request and response words
	localparam int OP_BITS  = 1;
	localparam int KEY_W    = 32;
	localparam int VALUE_W  = 32;

	// Request opcodes
	localparam logic [OP_BITS-1:0] OP_GET = 1'b0;
	localparam logic [OP_BITS-1:0] OP_PUT = 1'b1;

	typedef struct packed {
		logic [OP_BITS-1:0] opcode;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] write_value;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [VALUE_W-1:0] read_value;
	} rsp_t;

	// Command broadcast to every cell
	typedef enum logic [1:0] {
		CMD_NONE   = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_TOUCH  = 2'd2,
		CMD_INSERT = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      upd_value;  // touch also overwrites the value (put hit)
		logic      use_evict;  // insert reuses the least recent slot
	} cell_cmd_t;

	// Passed from each cell to the next one up the row
	typedef struct packed {
		logic               hit;         // some lower cell matched
		logic               free_seen;   // some lower cell is empty
		logic               evict_seen;  // some lower cell is least recent
		logic [VALUE_W-1:0] read_value;  // value of the matching cell, else zero
	} chain_t;

endpackage

`default_nettype wire

/* design/lru_lookup_cache_top.sv */
// Fully associative key/value cache with LRU replacement: a row of llc_cell
// slots joined by a priority chain. Uses llc_pkg and llc_cell.
`default_nettype none

// Usage:
//   req channel (req_valid/req_stall/req_data): one get or put word each.
//   rsp channel (rsp_valid/rsp_stall/rsp_data): exactly one response word per
//   request, in order. hit tells whether the key was present; read_value is
//   the stored value on a get hit and zero otherwise.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): writes the capacity and
//   empties the cache. Write it only while no request is in flight.
// The request word is registered in item_q; the response is registered in
//   rsp_q when that request commits. Throughput: one request per cycle while
//   no waiting response is stalled; the slot row compares and updates all
//   entries when the request commits, and the next request is taken in that same cycle.
// When rsp_stall is high with a response waiting, the pending request holds
//   in its register and req_stall goes high until the response is taken.
// Reset empties every slot and sets the capacity to 16; values zero and
//   above the slot count act as 1 and as the slot count.
module lru_lookup_cache_top #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              req_valid,
	output logic                             req_stall,
	input  llc_pkg::req_t                    req_data,
	output logic                             rsp_valid,
	input  wire                              rsp_stall,
	output llc_pkg::rsp_t                    rsp_data,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire  [llc_pkg::CAP_BITS-1:0]     cfg_data
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int LW = $clog2(MAX_ENTRIES + 1);
	localparam int EW = (LW > llc_pkg::CAP_BITS) ? LW : llc_pkg::CAP_BITS;

	logic                           busy_q;
	llc_pkg::req_t                  item_q;
	logic                           rsp_valid_q;
	llc_pkg::rsp_t                  rsp_q;
	logic [llc_pkg::CAP_BITS-1:0]   capacity_q;
	logic [LW-1:0]                  live_count_q;

	logic                           commit;
	logic                           accept;
	logic                           cfg_we;
	llc_pkg::cell_cmd_t             cmd;
	llc_pkg::chain_t                chain_w [MAX_ENTRIES+1];
	logic [MAX_ENTRIES-1:0]         match_w;
	logic [AW-1:0]                  age_w   [MAX_ENTRIES];
	logic [AW-1:0]                  found_age;
	logic [EW-1:0]                  cap_ext;
	logic [EW-1:0]                  eff_cap;
	logic                           need_evict;
	logic                           use_evict;
	logic                           slot_ok;
	logic                           is_put;
	logic                           hit;
	logic [llc_pkg::KEY_W-1:0]      item_key;
	logic [llc_pkg::VALUE_W-1:0]    item_value;

	// Handshakes
	assign commit    = busy_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall = busy_q && !commit;
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = !busy_q;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	assign item_key   = item_q.key;
	assign item_value = item_q.write_value;
	assign is_put     = (item_q.opcode == llc_pkg::OP_PUT);
	assign hit        = chain_w[MAX_ENTRIES].hit;

	// Effective capacity, clamped to 1 .. MAX_ENTRIES
	assign cap_ext = EW'(capacity_q);
	always_comb begin
		if (cap_ext == '0) begin
			eff_cap = EW'(1);
		end else if (cap_ext > EW'(MAX_ENTRIES)) begin
			eff_cap = EW'(MAX_ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
	end

	assign need_evict = (EW'(live_count_q) >= eff_cap);
	assign use_evict  = need_evict && chain_w[MAX_ENTRIES].evict_seen;
	assign slot_ok    = use_evict || chain_w[MAX_ENTRIES].free_seen;

	// Age of the matching slot
	always_comb begin
		found_age = '0;
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			found_age = found_age | (match_w[i] ? age_w[i] : '0);
		end
	end

	// Command to the slot row
	always_comb begin
		cmd.kind      = llc_pkg::CMD_NONE;
		cmd.upd_value = 1'b0;
		cmd.use_evict = use_evict;
		if (cfg_we) begin
			cmd.kind = llc_pkg::CMD_CLEAR;
		end else if (commit) begin
			if (hit) begin
				cmd.kind      = llc_pkg::CMD_TOUCH;
				cmd.upd_value = is_put;
			end else if (is_put && slot_ok) begin
				cmd.kind = llc_pkg::CMD_INSERT;
			end
		end
	end

	// Slot row
	assign chain_w[0] = '0;
	for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
		llc_cell #(
			.KEY_BITS   (llc_pkg::KEY_W),
			.VALUE_BITS (llc_pkg::VALUE_W),
			.AW         (AW),
			.LW         (LW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.key        (item_key),
			.wr_value   (item_value),
			.touch_age  (found_age),
			.live_count (live_count_q),
			.chain_in   (chain_w[g]),
			.chain_out  (chain_w[g+1]),
			.match      (match_w[g]),
			.age        (age_w[g])
		);
	end

	// Control: pending item, response valid, capacity, live count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
			capacity_q   <= llc_pkg::CAP_BITS'(16);
			live_count_q <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end

			if (commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				capacity_q   <= cfg_data;
				live_count_q <= '0;
			end else if (cmd.kind == llc_pkg::CMD_INSERT && !use_evict) begin
				live_count_q <= live_count_q + LW'(1);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req_data;
		end
		if (commit) begin
			rsp_q.hit        <= hit;
			rsp_q.read_value <= (!is_put && hit) ? chain_w[MAX_ENTRIES].read_value : '0;
		end
	end

endmodule

`default_nettype wire

/* design/llc_cell.sv */
// One cache slot: key, value, valid and recency age, with its compare and
// update logic. Uses llc_pkg for the command and chain structs.
`default_nettype none

module llc_cell #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32,
	parameter int AW         = 4,
	parameter int LW         = 5
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  llc_pkg::cell_cmd_t      cmd,
	input  wire  [KEY_BITS-1:0]     key,
	input  wire  [VALUE_BITS-1:0]   wr_value,
	input  wire  [AW-1:0]           touch_age,
	input  wire  [LW-1:0]           live_count,
	input  llc_pkg::chain_t         chain_in,
	output llc_pkg::chain_t         chain_out,
	output logic                    match,
	output logic [AW-1:0]           age
);

	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  valid_q;
	logic [AW-1:0]         age_q;
	logic                  evict_cand;
	logic                  target;

	assign match = valid_q && (key_q == key);
	assign age   = age_q;

	// Oldest live entry: age is live_count - 1
	assign evict_cand = valid_q && ((LW'(age_q) + LW'(1)) == live_count);

	// Pass first-match, first-free and first-evict info up the row
	always_comb begin
		chain_out.hit        = chain_in.hit | match;
		chain_out.free_seen  = chain_in.free_seen | !valid_q;
		chain_out.evict_seen = chain_in.evict_seen | evict_cand;
		chain_out.read_value = chain_in.read_value |
			(match ? llc_pkg::VALUE_W'(value_q) : '0);
	end

	// This slot takes the inserted entry
	assign target = cmd.use_evict ? (evict_cand && !chain_in.evict_seen)
	                              : (!valid_q && !chain_in.free_seen);

	// Valid and age
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else begin
			unique case (cmd.kind)
				llc_pkg::CMD_CLEAR: begin
					valid_q <= 1'b0;
					age_q   <= '0;
				end
				llc_pkg::CMD_TOUCH: begin
					if (match) begin
						age_q <= '0;
					end else if (valid_q && (age_q < touch_age)) begin
						age_q <= age_q + AW'(1);
					end
				end
				llc_pkg::CMD_INSERT: begin
					if (target) begin
						valid_q <= 1'b1;
						age_q   <= '0;
					end else if (valid_q) begin
						age_q <= age_q + AW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Key and value payload
	always_ff @(posedge clk) begin
		if (cmd.kind == llc_pkg::CMD_INSERT && target) begin
			key_q   <= key;
			value_q <= wr_value;
		end else if (cmd.kind == llc_pkg::CMD_TOUCH && cmd.upd_value && match) begin
			value_q <= wr_value;
		end
	end

endmodule

`default_nettype wire

/* tb/tb_lru_lookup_cache_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for lru_lookup_cache_top: an LRU predictor in a small
// scoreboard class, plus request, response-stall and capacity-write drivers.
// Depends on llc_pkg and the lru_lookup_cache_top RTL.

// Tracks the expected cache contents and checks each response word in order
class cache_scoreboard;
	localparam int SLOTS = 16;

	logic [31:0] slot_key  [SLOTS];
	logic [31:0] slot_val  [SLOTS];
	bit          slot_live [SLOTS];
	int unsigned slot_rank [SLOTS];  // 0 = most recent
	int unsigned live_cnt;
	logic [llc_pkg::CAP_BITS-1:0] cap_reg;

	llc_pkg::rsp_t expected_rsp_q[$];
	int errors;
	int checked;
	int hits;
	int evictions;

	function new();
		errors    = 0;
		checked   = 0;
		hits      = 0;
		evictions = 0;
		set_capacity(5'd16);
	endfunction

	function int pending();
		return expected_rsp_q.size();
	endfunction

	// Any capacity write empties the store
	function void set_capacity(logic [llc_pkg::CAP_BITS-1:0] v);
		cap_reg = v;
		for (int i = 0; i < SLOTS; i++) begin
			slot_live[i] = 1'b0;
			slot_rank[i] = 0;
		end
		live_cnt = 0;
	endfunction

	// Out-of-range values clamp to 1 .. SLOTS
	function int unsigned eff_capacity();
		if (cap_reg == 0)
			return 1;
		if (cap_reg > SLOTS)
			return SLOTS;
		return cap_reg;
	endfunction

	// Move slot s to most recent; entries that were newer age by one
	function void promote(int s);
		int unsigned r;
		r = slot_rank[s];
		for (int i = 0; i < SLOTS; i++)
			if (slot_live[i] && i != s && slot_rank[i] < r)
				slot_rank[i]++;
		slot_rank[s] = 0;
	endfunction

	// Accepted request word: update the model and queue the expected response
	function void note_request(llc_pkg::req_t r);
		llc_pkg::rsp_t exp_rsp;
		int found;
		int slot;
		found = -1;
		slot  = -1;
		for (int i = 0; i < SLOTS; i++)
			if (slot_live[i] && slot_key[i] == r.key) begin
				found = i;
				break;
			end
		exp_rsp.hit        = (found >= 0);
		exp_rsp.read_value = '0;
		if (found >= 0)
			hits++;
		if (r.opcode == llc_pkg::OP_GET) begin
			if (found >= 0) begin
				exp_rsp.read_value = slot_val[found];
				promote(found);
			end
		end else if (found >= 0) begin
			slot_val[found] = r.write_value;
			promote(found);
		end else begin
			// full: drop the least recent entry and reuse its slot
			if (live_cnt >= eff_capacity()) begin
				for (int i = 0; i < SLOTS; i++)
					if (slot_live[i] && slot_rank[i] + 1 == live_cnt) begin
						slot = i;
						break;
					end
				if (slot >= 0) begin
					slot_live[slot] = 1'b0;
					live_cnt--;
					evictions++;
				end
			end
			// otherwise the lowest free slot
			if (slot < 0)
				for (int i = 0; i < SLOTS; i++)
					if (!slot_live[i]) begin
						slot = i;
						break;
					end
			if (slot >= 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (slot_live[i])
						slot_rank[i]++;
				slot_key[slot]  = r.key;
				slot_val[slot]  = r.write_value;
				slot_live[slot] = 1'b1;
				slot_rank[slot] = 0;
				live_cnt++;
			end
		end
		expected_rsp_q.push_back(exp_rsp);
	endfunction

	// Accepted response word: compare with the oldest expectation
	function void check_response(llc_pkg::rsp_t got);
		llc_pkg::rsp_t exp_rsp;
		if (expected_rsp_q.size() == 0) begin
			$error("response word with no request outstanding: hit=%0d read_value=%h",
				got.hit, got.read_value);
			errors++;
			return;
		end
		exp_rsp = expected_rsp_q.pop_front();
		checked++;
		if (got.hit !== exp_rsp.hit) begin
			$error("hit mismatch: expected %0d, actual %0d", exp_rsp.hit, got.hit);
			errors++;
		end
		if (got.read_value !== exp_rsp.read_value) begin
			$error("read_value mismatch: expected %h, actual %h",
				exp_rsp.read_value, got.read_value);
			errors++;
		end
	endfunction
endclass

module tb_lru_lookup_cache_top;

	localparam int CYCLE_LIMIT = 400000;
	localparam int N_PHASES    = 12;
	localparam int PHASE_ITEMS = 120;
	localparam int POOL_MAX    = 40;

	logic                         clk;
	logic                         arst_n;
	logic                         req_valid;
	logic                         req_stall;
	llc_pkg::req_t                req_data;
	logic                         rsp_valid;
	logic                         rsp_stall;
	llc_pkg::rsp_t                rsp_data;
	logic                         cfg_valid;
	logic                         cfg_ready;
	logic [llc_pkg::CAP_BITS-1:0] cfg_data;

	cache_scoreboard sb;
	int unsigned     cycles;
	int              n_sent;
	int              n_cfg;
	logic [31:0]     key_pool [POOL_MAX];

	// stall pattern state
	int unsigned     stall_mode;
	int unsigned     stall_run;
	int unsigned     mode_cnt;

	lru_lookup_cache_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// Sample every handshake at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (cfg_valid && cfg_ready) begin
				sb.set_capacity(cfg_data);
				n_cfg++;
			end
			if (req_valid && !req_stall)
				sb.note_request(req_data);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp_data);
			if (cycles > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles, %0d responses outstanding",
					cycles, sb.pending());
				$display("FAIL");
				$finish;
			end
		end
	end

	// Receiver stall: picks a new mode (none, scattered, long runs) each time mode_cnt runs out
	always @(negedge clk) begin
		if (mode_cnt == 0) begin
			stall_mode = $urandom_range(2, 0);
			mode_cnt   = 100;
		end
		mode_cnt--;
		if (stall_run > 0) begin
			stall_run--;
			rsp_stall <= 1'b1;
		end else if (stall_mode == 1) begin
			rsp_stall <= ($urandom_range(3, 0) == 0);
		end else if (stall_mode == 2 && $urandom_range(7, 0) == 0) begin
			stall_run = $urandom_range(8, 1);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Present one request word and hold it until taken
	task automatic send_request(input logic [llc_pkg::OP_BITS-1:0] op,
			input logic [31:0] k, input logic [31:0] v);
		llc_pkg::req_t r;
		r.opcode      = op;
		r.key         = k;
		r.write_value = v;
		@(negedge clk);
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		n_sent++;
	endtask

	// Sender gap; payload wanders while valid is low
	task automatic sender_pause(input int n);
		repeat (n) begin
			@(negedge clk);
			req_valid <= 1'b0;
			req_data  <= $bits(llc_pkg::req_t)'({$urandom, $urandom, $urandom});
		end
	endtask

	task automatic wait_drained();
		sender_pause(1);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (3)
			@(posedge clk);
	endtask

	// Capacity write, only once the pipe is empty
	task automatic write_capacity(input logic [llc_pkg::CAP_BITS-1:0] v);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random phase: bursts of requests over a key pool sized around the capacity
	task automatic run_phase(input logic [llc_pkg::CAP_BITS-1:0] cap, input int n_items);
		int unsigned eff;
		int unsigned pool_n;
		int          burst;
		int          gap;
		logic [31:0] k;
		write_capacity(cap);
		eff    = (cap == 0) ? 1 : (cap > 16) ? 16 : cap;
		pool_n = eff + $urandom_range(eff + 4, 0);
		if (pool_n > POOL_MAX)
			pool_n = POOL_MAX;
		for (int i = 0; i < POOL_MAX; i++)
			key_pool[i] = $urandom;
		burst = 0;
		for (int i = 0; i < n_items; i++) begin
			if (burst == 0) begin
				burst = ($urandom_range(9, 0) == 0) ? 60 : $urandom_range(16, 1);
				gap   = $urandom_range(4, 0);
				if (gap > 0)
					sender_pause(gap);
			end
			burst--;
			// mostly pool keys; a few stray ones that should miss
			if ($urandom_range(9, 0) == 0)
				k = $urandom;
			else
				k = key_pool[$urandom_range(pool_n - 1, 0)];
			send_request($urandom_range(1, 0) ? llc_pkg::OP_PUT : llc_pkg::OP_GET,
				k, $urandom);
		end
	endtask

	initial begin
		clk        = 1'b0;
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req_data   = '0;
		rsp_stall  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		cycles     = 0;
		n_sent     = 0;
		n_cfg      = 0;
		stall_mode = 0;
		stall_run  = 0;
		mode_cnt   = 0;
		sb = new();
		repeat (6)
			@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extreme keys and values at reset capacity
		send_request(llc_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(llc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(llc_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(llc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(llc_pkg::OP_GET, 32'h1234_5678, 32'h0);
		// put hit overwrites the value
		send_request(llc_pkg::OP_PUT, 32'h0000_0000, 32'hA5A5_A5A5);
		send_request(llc_pkg::OP_GET, 32'h0000_0000, 32'h5A5A_5A5A);

		// Two entries: a recent get protects its key from eviction
		write_capacity(5'd2);
		send_request(llc_pkg::OP_PUT, 32'hAAAA_0001, 32'h1111_1111);
		send_request(llc_pkg::OP_PUT, 32'hAAAA_0002, 32'h2222_2222);
		send_request(llc_pkg::OP_GET, 32'hAAAA_0001, 32'h0);
		send_request(llc_pkg::OP_PUT, 32'hAAAA_0003, 32'h3333_3333);
		send_request(llc_pkg::OP_GET, 32'hAAAA_0002, 32'h0);
		send_request(llc_pkg::OP_GET, 32'hAAAA_0001, 32'h0);
		send_request(llc_pkg::OP_GET, 32'hAAAA_0003, 32'h0);

		// Zero capacity behaves as one entry
		write_capacity(5'd0);
		send_request(llc_pkg::OP_PUT, 32'h5555_0001, 32'hDEAD_0001);
		send_request(llc_pkg::OP_PUT, 32'h5555_0002, 32'hDEAD_0002);
		send_request(llc_pkg::OP_GET, 32'h5555_0001, 32'h0);
		send_request(llc_pkg::OP_GET, 32'h5555_0002, 32'h0);
		// rewriting the same capacity still empties the cache
		write_capacity(5'd0);
		send_request(llc_pkg::OP_GET, 32'h5555_0002, 32'h0);

		// Random phases; 31 and 17 exceed the slot count
		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: run_phase(5'd16, PHASE_ITEMS);
				1: run_phase(5'd1, PHASE_ITEMS);
				2: run_phase(5'd31, PHASE_ITEMS);
				3: run_phase(5'd17, PHASE_ITEMS);
				4: run_phase(5'd0, PHASE_ITEMS);
				5: run_phase(5'd2, PHASE_ITEMS);
				6: run_phase(5'd15, PHASE_ITEMS);
				default: run_phase(llc_pkg::CAP_BITS'($urandom_range(31, 0)), PHASE_ITEMS);
			endcase
		end

		wait_drained();
		$display("Sent %0d request words across %0d capacity writes; %0d responses checked.",
			n_sent, n_cfg, sb.checked);
		$display("Model saw %0d hits and %0d evictions.", sb.hits, sb.evictions);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
